[hw/rtl/hsc_pkg.sv]
// ----------------------------------------------------------------------------
// hsc_pkg: shared types and constants of the Hall commutator
// Register map codes, commutation tables and the structs passed between units.
// ----------------------------------------------------------------------------
package hsc_pkg;

	localparam int unsigned DUTY_W   = 9;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned TIME_W   = 17;
	localparam int unsigned GATE_W   = 6;

	localparam logic [DUTY_W-1:0]   DUTY_ONE     = 9'd256;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10000;
	localparam logic [TIME_W-1:0]   TIME_MAX     = 17'h1FFFF;

	// Register indexes on the configuration port (word address).
	localparam logic [1:0] REG_DUTY      = 2'd0;
	localparam logic [1:0] REG_DIRECTION = 2'd1;
	localparam logic [1:0] REG_PERIOD    = 2'd2;

	// Gate bit order: a_high, a_low, b_high, b_low, c_high, c_low from bit 0.
	// Hall index is c,b,a from the top; 000 and 111 leave every switch off.
	localparam logic [GATE_W-1:0] PATTERN_CW [8] = '{
		6'h00, 6'h21, 6'h06, 6'h24, 6'h18, 6'h09, 6'h12, 6'h00
	};
	localparam logic [GATE_W-1:0] PATTERN_ACW [8] = '{
		6'h00, 6'h12, 6'h09, 6'h18, 6'h24, 6'h06, 6'h21, 6'h00
	};

	typedef struct packed {
		logic [DUTY_W-1:0]   duty;
		logic                direction;
		logic [PERIOD_W-1:0] period;
	} cfg_t;

	typedef struct packed {
		logic [GATE_W-1:0] pattern;
		logic              hall_edge;
	} comm_t;

	typedef struct packed {
		logic [GATE_W-1:0] gate;
		logic              bridge_on;
	} drive_t;

endpackage

[hw/rtl/hsc_apb_regs.sv]
// ----------------------------------------------------------------------------
// hsc_apb_regs: configuration registers
// Holds duty, direction and period behind an APB-style port.
// ----------------------------------------------------------------------------
module hsc_apb_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output hsc_pkg::cfg_t      cfg
);

	logic [hsc_pkg::DUTY_W-1:0]   duty_q;
	logic                         direction_q;
	logic [hsc_pkg::PERIOD_W-1:0] period_q;
	logic                         wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q      <= hsc_pkg::DUTY_ONE;
			direction_q <= 1'b0;
			period_q    <= hsc_pkg::PERIOD_RESET;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				hsc_pkg::REG_DUTY:      duty_q      <= pwdata[hsc_pkg::DUTY_W-1:0];
				hsc_pkg::REG_DIRECTION: direction_q <= pwdata[0];
				hsc_pkg::REG_PERIOD:    period_q    <= pwdata[hsc_pkg::PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			hsc_pkg::REG_DUTY:      prdata = {23'd0, duty_q};
			hsc_pkg::REG_DIRECTION: prdata = {31'd0, direction_q};
			hsc_pkg::REG_PERIOD:    prdata = {16'd0, period_q};
			default:                prdata = 32'd0;
		endcase
	end

	assign cfg = '{duty: duty_q, direction: direction_q, period: period_q};

endmodule

[hw/rtl/hsc_commutator.sv]
// ----------------------------------------------------------------------------
// hsc_commutator: Hall decode and edge detection
// Looks up the six-step pattern and flags a change of the Hall bit count to a nonzero value.
// ----------------------------------------------------------------------------
module hsc_commutator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          update,
	input  logic [2:0]    hall,
	input  logic          direction,
	output hsc_pkg::comm_t comm
);

	logic [2:0] last_hall_q;
	logic [1:0] old_sum;
	logic [1:0] new_sum;

	assign old_sum = 2'(last_hall_q[0]) + 2'(last_hall_q[1]) + 2'(last_hall_q[2]);
	assign new_sum = 2'(hall[0]) + 2'(hall[1]) + 2'(hall[2]);

	assign comm.hall_edge = ((old_sum == 2'd0) || (old_sum != new_sum)) && (new_sum != 2'd0);
	assign comm.pattern   = direction ? hsc_pkg::PATTERN_ACW[hall] : hsc_pkg::PATTERN_CW[hall];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_hall_q <= 3'd0;
		end else if (update) begin
			last_hall_q <= hall;
		end
	end

endmodule

[hw/rtl/hsc_pwm_core.sv]
// ----------------------------------------------------------------------------
// hsc_pwm_core: software PWM timer and gate state
// Accumulates elapsed time, toggles the bridge and holds the gate drive.
// ----------------------------------------------------------------------------
module hsc_pwm_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         update,
	input  logic [hsc_pkg::PERIOD_W-1:0] elapsed,
	input  hsc_pkg::comm_t               comm,
	input  hsc_pkg::cfg_t                cfg,
	output hsc_pkg::drive_t              drive_next
);

	logic [hsc_pkg::GATE_W-1:0]   gate_drive_q;
	logic                         on_phase_q;
	logic [hsc_pkg::TIME_W-1:0]   time_in_phase_q;
	logic [hsc_pkg::PERIOD_W-1:0] phase_length_q;

	logic [hsc_pkg::DUTY_W-1:0]   duty;
	logic [hsc_pkg::DUTY_W-1:0]   factor;
	logic [23:0]                  product;
	logic [hsc_pkg::TIME_W:0]     time_sum;
	logic [hsc_pkg::TIME_W-1:0]   time_sat;
	logic                         phase_end;

	logic [hsc_pkg::GATE_W-1:0]   gate_next;
	logic                         on_next;
	logic [hsc_pkg::TIME_W-1:0]   time_next;
	logic [hsc_pkg::PERIOD_W-1:0] length_next;

	// Duty codes above one are taken as fully on.
	assign duty    = (cfg.duty > hsc_pkg::DUTY_ONE) ? hsc_pkg::DUTY_ONE : cfg.duty;
	// The next phase is off-time when the bridge is on now, else on-time.
	assign factor  = on_phase_q ? (hsc_pkg::DUTY_ONE - duty) : duty;
	assign product = 24'(cfg.period) * 24'(factor);

	assign time_sum  = 18'(time_in_phase_q) + 18'(elapsed);
	assign time_sat  = time_sum[hsc_pkg::TIME_W] ? hsc_pkg::TIME_MAX
	                                             : time_sum[hsc_pkg::TIME_W-1:0];
	assign phase_end = time_sat >= 17'(phase_length_q);

	always_comb begin
		gate_next   = gate_drive_q;
		on_next     = on_phase_q;
		time_next   = time_sat;
		length_next = phase_length_q;
		if (phase_end) begin
			time_next   = '0;
			on_next     = !on_phase_q;
			gate_next   = on_phase_q ? '0 : comm.pattern;
			length_next = product[23:8];
		end else if (on_phase_q && comm.hall_edge) begin
			gate_next = comm.pattern;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_drive_q    <= '0;
			on_phase_q      <= 1'b0;
			time_in_phase_q <= '0;
			phase_length_q  <= '0;
		end else if (update) begin
			gate_drive_q    <= gate_next;
			on_phase_q      <= on_next;
			time_in_phase_q <= time_next;
			phase_length_q  <= length_next;
		end
	end

	assign drive_next = '{gate: gate_next, bridge_on: on_next};

endmodule

[hw/rtl/hall_six_step_commutator_pwm_unit.sv]
// ----------------------------------------------------------------------------
// hall_six_step_commutator_pwm_unit: six-step Hall commutator with PWM
// The result register offers a result after its request leaves stage one.
// One request per cycle unless results stall; the timer state updates per request.
// The input register and the result register run as a two-entry pipeline.
// Reset clears the pipeline, Hall history, timer and gates; registers take
// their documented reset values (full duty, clockwise, 10000 us period).
// ----------------------------------------------------------------------------
module hall_six_step_commutator_pwm_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream requests.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // hall_a, hall_b, hall_c, elapsed_us[15:0], zero fill
	// Result stream requests.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // a_high, a_low, b_high, b_low, c_high, c_low,
	                               // bridge_on, hall_edge
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	hsc_pkg::cfg_t   cfg;
	hsc_pkg::comm_t  comm;
	hsc_pkg::drive_t drive_next;

	// Stage one holds the accepted request; the result register holds its answer.
	logic        valid_s1;
	logic [2:0]  hall_s1;
	logic [15:0] elapsed_s1;
	logic        out_valid_q;
	logic [7:0]  out_data_q;
	logic        advance;
	logic        update;

	// The result register can take a new answer when it is empty or being drained.
	assign advance  = !out_valid_q || m_tready;
	// Stage one can accept whenever it is empty or moving on in this cycle.
	assign s_tready = !valid_s1 || advance;
	// The state of the commutator and the timer moves once per request.
	assign update   = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			hall_s1    <= s_tdata[2:0];
			elapsed_s1 <= s_tdata[18:3];
		end
	end

	hsc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hsc_commutator u_comm (
		.clk       (clk),
		.arst_n    (arst_n),
		.update    (update),
		.hall      (hall_s1),
		.direction (cfg.direction),
		.comm      (comm)
	);

	hsc_pwm_core u_pwm (
		.clk        (clk),
		.arst_n     (arst_n),
		.update     (update),
		.elapsed    (elapsed_s1),
		.comm       (comm),
		.cfg        (cfg),
		.drive_next (drive_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// The result is packed with the gates in the low bits, then bridge and edge.
	always_ff @(posedge clk) begin
		if (update) begin
			out_data_q <= {comm.hall_edge, drive_next.bridge_on, drive_next.gate};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Gates can only be driven during on-time.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[5:0] != 6'd0) |-> m_tdata[6])
		else $error("gates driven while bridge is off");

	// No phase ever has its source and sink switch on together.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]) && !(m_tdata[2] && m_tdata[3])
		             && !(m_tdata[4] && m_tdata[5]))
		else $error("shoot-through in gate pattern");

	// An empty result register never blocks the input side.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty result register");

	// A request held in stage one stays there until it can move on.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(hall_s1) && $stable(elapsed_s1))
		else $error("stalled request lost from stage one");

endmodule
